@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the packed bit-field array.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pba assertion failed (same-cycle implication)");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pba assertion failed (next-cycle implication)");

`endif

@@ rtl/pba_pkg.sv @@
// Shared constants and types of the packed bit-field array.
package pba_pkg;

    localparam int IDX_W         = 13;
    localparam int VAL_W         = 32;
    localparam int CFG_W         = 6;
    localparam int S_TDATA_W     = 48;
    localparam int MEM_BYTES_DEF = 1024;
    localparam int MAX_WIDTH_DEF = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd8;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Strobes from the sequencer to the byte store.
    typedef struct packed {
        logic rd;
        logic wr;
    } mem_ctl_t;

endpackage

@@ rtl/pba_store.sv @@
// Byte store: up to one write and one registered read per cycle.
module pba_store #(
    parameter int MEM_BYTES = pba_pkg::MEM_BYTES_DEF
) (
    input  logic                         clk,
    input  pba_pkg::mem_ctl_t            ctl,
    input  logic [$clog2(MEM_BYTES)-1:0] addr,
    input  logic [7:0]                   wdata,
    output logic [7:0]                   rdata
);
    import pba_pkg::*;

    logic [7:0] mem [MEM_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pba_ctrl.sv @@
// Sequencer: element span arithmetic and the byte-at-a-time merge unit.
module pba_ctrl #(
    parameter int MEM_BYTES = pba_pkg::MEM_BYTES_DEF,
    parameter int MAX_WIDTH = pba_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         cmd,
    input  logic [pba_pkg::IDX_W-1:0]    idx,
    input  logic [pba_pkg::VAL_W-1:0]    val,
    input  logic [pba_pkg::CFG_W-1:0]    width,
    input  logic                         out_free,
    output logic                         idle,
    output logic                         done,
    output logic [pba_pkg::VAL_W-1:0]    res_value,
    output logic                         res_oor,
    output pba_pkg::mem_ctl_t            mem_ctl,
    output logic [$clog2(MEM_BYTES)-1:0] mem_addr,
    output logic [7:0]                   mem_wdata,
    input  logic [7:0]                   mem_rdata
);
    import pba_pkg::*;

    localparam int AW     = $clog2(MEM_BYTES);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int PROD_W = IDX_W + WW;
    localparam int NB_MAX = (MAX_WIDTH + 14) / 8;
    localparam int CNT_W  = (NB_MAX > 1) ? $clog2(NB_MAX) : 1;
    localparam int ACC_W  = 8 * NB_MAX;
    localparam logic [31:0] TOTAL_BITS = 32'(MEM_BYTES * 8);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_MRG   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic                        cmd_reg, cmd_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [VAL_W-1:0]            val_reg, val_next;
    logic [PROD_W-1:0]           start_reg, start_next;
    logic [AW-1:0]               addr_reg, addr_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [NB_MAX-1:0][7:0]      wdat_reg, wdat_next;
    logic [NB_MAX-1:0][7:0]      wmsk_reg, wmsk_next;
    logic [ACC_W-1:0]            acc_reg, acc_next;
    logic [2:0]                  tail_reg, tail_next;
    logic                        oor_reg, oor_next;

    logic [WW-1:0]    w_eff;
    logic [ACC_W-1:0] elem_mask;
    logic [PROD_W-1:0] end_c;
    logic [2:0]       tail_c;
    logic             oor_c;
    logic [31:0]      lo32;
    logic [31:0]      hi32;
    logic [ACC_W-1:0] res_full;
    logic [7:0]       byte_mask;
    logic [7:0]       byte_data;

    // Widths above the supported maximum saturate.
    assign w_eff     = (width > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width);
    assign elem_mask = (ACC_W'(1) << w_eff) - ACC_W'(1);

    always_comb
    begin
        end_c     = start_reg + PROD_W'(w_eff);
        // Bits of the last byte that lie after the element's least significant bit.
        tail_c    = 3'(3'd0 - end_c[2:0]);
        oor_c     = 32'(end_c) > TOTAL_BITS;
        lo32      = 32'(start_reg) >> 3;
        hi32      = (32'(end_c) - 32'd1) >> 3;
        res_full  = (acc_reg >> tail_reg) & elem_mask;
        byte_mask = wmsk_reg[cnt_reg];
        byte_data = wdat_reg[cnt_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        start_next = start_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        wdat_next  = wdat_reg;
        wmsk_next  = wmsk_reg;
        acc_next   = acc_reg;
        tail_next  = tail_reg;
        oor_next   = oor_reg;
        mem_ctl    = '0;
        mem_wdata  = (mem_rdata & ~byte_mask) | (byte_data & byte_mask);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    idx_next   = idx;
                    val_next   = val;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                start_next = PROD_W'(idx_reg) * PROD_W'(w_eff);
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                tail_next  = tail_c;
                oor_next   = oor_c;
                addr_next  = AW'(lo32);
                cnt_next   = CNT_W'(hi32 - lo32);
                acc_next   = '0;
                wdat_next  = (ACC_W'(val_reg) & elem_mask) << tail_c;
                wmsk_next  = elem_mask << tail_c;
                if (oor_c || (w_eff == '0))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                mem_ctl.rd = 1'b1;
                state_next = S_MRG;
            end
            S_MRG:
            begin
                mem_ctl.wr = (cmd_reg == CMD_WRITE);
                acc_next   = {acc_reg[ACC_W-9:0], mem_rdata};
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    addr_next  = addr_reg + AW'(1);
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        val_reg   <= val_next;
        start_reg <= start_next;
        addr_reg  <= addr_next;
        cnt_reg   <= cnt_next;
        wdat_reg  <= wdat_next;
        wmsk_reg  <= wmsk_next;
        acc_reg   <= acc_next;
        tail_reg  <= tail_next;
        oor_reg   <= oor_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign done      = (state_reg == S_FIN) && out_free;
    assign res_oor   = oor_reg;
    assign res_value = ((cmd_reg == CMD_READ) && !oor_reg) ? VAL_W'(res_full) : '0;
    assign mem_addr  = addr_reg;

endmodule

@@ rtl/packed_bitfield_array.sv @@
// Items are processed one at a time: s_tready stays low until the sequencer is idle again.
// An element touches n bytes, n from 1 to (MAX_WIDTH + 14) / 8; each byte is read from
// the byte store in one state and merged and written back in the next, and an out-of-range
// or zero-width item skips the byte accesses; the result waits in an output register.
// Reset clears the sequencer, the output valid and sets element_width to 8;
// the byte store is not cleared.
module packed_bitfield_array #(
    parameter int MEM_BYTES = pba_pkg::MEM_BYTES_DEF,
    parameter int MAX_WIDTH = pba_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pba_pkg::S_TDATA_W-1:0]   s_tdata,   // element_index, write_value, zero pad
    input  logic                            s_tuser,   // command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pba_pkg::VAL_W-1:0]       m_tdata,   // read_value
    output logic                            m_tuser,   // out_of_range
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pba_pkg::CFG_W-1:0]       cfg_data   // element_width
);
    import pba_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    logic [CFG_W-1:0] element_width_reg;
    logic             out_valid_reg;
    logic [VAL_W-1:0] read_value_reg;
    logic             out_of_range_reg;

    logic             idle;
    logic             done;
    logic             out_free;
    logic [VAL_W-1:0] res_value;
    logic             res_oor;
    mem_ctl_t         mem_ctl;
    logic [AW-1:0]    mem_addr;
    logic [7:0]       mem_wdata;
    logic [7:0]       mem_rdata;

    assign cfg_ready = 1'b1;
    assign s_tready  = idle;
    assign out_free  = !out_valid_reg || m_tready;

    pba_ctrl #(
        .MEM_BYTES (MEM_BYTES),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid && s_tready),
        .cmd       (s_tuser),
        .idx       (s_tdata[IDX_W-1:0]),
        .val       (s_tdata[IDX_W +: VAL_W]),
        .width     (element_width_reg),
        .out_free  (out_free),
        .idle      (idle),
        .done      (done),
        .res_value (res_value),
        .res_oor   (res_oor),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    pba_store #(
        .MEM_BYTES (MEM_BYTES)
    ) u_store (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_width_reg <= WIDTH_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                element_width_reg <= cfg_data;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            read_value_reg   <= res_value;
            out_of_range_reg <= res_oor;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = read_value_reg;
    assign m_tuser  = out_of_range_reg;

endmodule

@@ rtl/pba_checker.sv @@
// Port-level checker for the packed bit-field array, bound to the top level.
`include "assert_macros.svh"

module pba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result keeps its value.
    `PBA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // The block works on one item at a time, so it is busy right after an accept.
    `PBA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // An out-of-range access never returns data.
    `PBA_ASSERT_IMPLY(a_oor_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == 32'd0)

endmodule

bind packed_bitfield_array pba_checker u_pba_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
